/* hw/rtl/adcs_pkg.sv */
// Types, codes and helper functions shared by the ADC averaging scanner files.
package adcs_pkg;

   localparam int ModeW = 2;
   localparam int SampleW = 10;
   localparam int SumW = 16;
   localparam int MuxW = 6;
   localparam int ChanW = 5;
   localparam int TotalW = 32;
   localparam int KindW = 2;

   // Input item codes.
   localparam logic [ModeW-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [ModeW-1:0] MODE_UP = 2'd1;
   localparam logic [ModeW-1:0] MODE_DOWN = 2'd2;

   // Result item codes.
   localparam logic [KindW-1:0] KIND_BUTTON = 2'd0;
   localparam logic [KindW-1:0] KIND_USER = 2'd1;
   localparam logic [KindW-1:0] KIND_CHANNEL = 2'd2;

   localparam logic [ChanW-1:0] BAND_GAP_CHANNEL = 5'd16;
   localparam logic [MuxW-1:0] BAND_GAP_MUX = 6'h1e;

   typedef struct packed {
      logic [KindW-1:0] result_kind;
      logic [SumW-1:0] average_sum;
      logic [MuxW-1:0] next_mux;
      logic [ChanW-1:0] user_channel;
      logic [TotalW-1:0] conversions;
   } rsp_payload_type;

   typedef struct packed {
      logic step_up;
      logic step_down;
   } step_cmd_type;

   typedef struct packed {
      logic [ChanW-1:0] channel;
      logic [MuxW-1:0] mux;
      logic [ChanW-1:0] channel_next;
      logic [MuxW-1:0] mux_next;
   } chan_status_type;

   // Channels 0..15 get two zero bits inserted above bit 2; bit 3 lands on bit 5.
   function automatic logic [MuxW-1:0] chan_to_mux(input logic [ChanW-1:0] ch);
      logic [MuxW-1:0] code;
      code = {ch[3], 2'b00, ch[2:0]};
      if (ch == BAND_GAP_CHANNEL) begin
         code = BAND_GAP_MUX;
      end
      return code;
   endfunction

endpackage

/* hw/rtl/adcs_if.sv */
// Handshake channel interfaces of the ADC averaging scanner.
interface adcs_req_if;
   logic valid;
   logic ready;
   logic [adcs_pkg::ModeW-1:0] mode;
   logic [adcs_pkg::SampleW-1:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink (input valid, input mode, input sample, output ready);
endinterface

interface adcs_rsp_if;
   logic valid;
   logic ready;
   adcs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface adcs_csr_if;
   logic valid;
   logic ready;
   logic [adcs_pkg::MuxW-1:0] button_mux_code;

   modport source (output valid, output button_mux_code, input ready);
   modport sink (input valid, input button_mux_code, output ready);
endinterface

/* hw/rtl/adcs_channel.sv */
// User channel selector: steps the channel with wrap and keeps its multiplexer code.
module adcs_channel (
   input  logic                       clock,
   input  logic                       reset,
   input  adcs_pkg::step_cmd_type     step,
   output adcs_pkg::chan_status_type  status
);

   logic [adcs_pkg::ChanW-1:0] channel_ff, channel_in;
   logic [adcs_pkg::MuxW-1:0] mux_ff, mux_in;

   always_comb begin
      channel_in = channel_ff;
      if (step.step_up) begin
         channel_in = (channel_ff >= adcs_pkg::BAND_GAP_CHANNEL) ? '0
                      : channel_ff + adcs_pkg::ChanW'(1);
      end else if (step.step_down) begin
         channel_in = (channel_ff == '0 || channel_ff > adcs_pkg::BAND_GAP_CHANNEL)
                      ? adcs_pkg::BAND_GAP_CHANNEL : channel_ff - adcs_pkg::ChanW'(1);
      end
      mux_in = (step.step_up || step.step_down) ? adcs_pkg::chan_to_mux(channel_in) : mux_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= adcs_pkg::BAND_GAP_CHANNEL;
         mux_ff <= adcs_pkg::BAND_GAP_MUX;
      end else begin
         channel_ff <= channel_in;
         mux_ff <= mux_in;
      end
   end

   assign status.channel = channel_ff;
   assign status.mux = mux_ff;
   assign status.channel_next = channel_in;
   assign status.mux_next = mux_in;

endmodule

/* hw/rtl/adc_two_channel_averaging_scanner.sv */
// The scanner takes one item per clock while its skid entry is empty: a sample is added
// to the running sum in the cycle it is accepted, and a channel step updates the user
// channel in that same cycle, so the state is always current for the next item. Results
// leave through an output register backed by one skid entry, in the cycle after the item
// that causes them when the result side is ready and later while it stalls. The input is
// ready whenever the skid entry is empty, so a stalled result side holds the input off
// only after two results are waiting. A series result comes every AVG_COUNT samples
// and alternates between the button and the user input; configuration writes are
// taken in any cycle.
module adc_two_channel_averaging_scanner #(
   parameter int AVG_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   adcs_req_if.sink    req,
   adcs_rsp_if.source  rsp,
   adcs_csr_if.sink    csr
);

   localparam int CntW = $clog2(AVG_COUNT + 1);
   localparam logic [CntW-1:0] CntLoad = CntW'(AVG_COUNT);

   logic [adcs_pkg::MuxW-1:0] button_mux_ff;
   logic reading_button_ff, reading_button_in;
   logic [CntW-1:0] samples_left_ff, samples_left_in;
   logic [adcs_pkg::SumW-1:0] running_sum_ff, running_sum_in;
   logic [adcs_pkg::TotalW-1:0] sample_total_ff, sample_total_in;

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   adcs_pkg::rsp_payload_type out_ff, out_in;
   adcs_pkg::rsp_payload_type skid_ff, skid_in;

   logic accept;
   logic is_sample;
   logic series_done;
   logic new_valid;
   logic pop;
   logic [adcs_pkg::SumW-1:0] sum_next;
   adcs_pkg::rsp_payload_type new_rsp;
   adcs_pkg::step_cmd_type step;
   adcs_pkg::chan_status_type chan;

   assign csr.ready = 1'b1;
   assign req.ready = !skid_valid_ff;
   assign accept = req.valid && req.ready;
   assign pop = out_valid_ff && rsp.ready;

   always_comb begin
      step = '0;
      is_sample = 1'b0;
      unique case (req.mode)
         adcs_pkg::MODE_SAMPLE: is_sample = accept;
         adcs_pkg::MODE_UP: step.step_up = accept;
         adcs_pkg::MODE_DOWN: step.step_down = accept;
         default: ;
      endcase
   end

   adcs_channel u_channel (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .status (chan)
   );

   assign sum_next = running_sum_ff + adcs_pkg::SumW'(req.sample);
   assign series_done = is_sample && (samples_left_ff == CntW'(1));

   always_comb begin
      reading_button_in = reading_button_ff;
      samples_left_in = samples_left_ff;
      running_sum_in = running_sum_ff;
      sample_total_in = sample_total_ff;
      if (is_sample) begin
         sample_total_in = sample_total_ff + adcs_pkg::TotalW'(1);
         if (series_done) begin
            reading_button_in = !reading_button_ff;
            samples_left_in = CntLoad;
            running_sum_in = '0;
         end else begin
            samples_left_in = samples_left_ff - CntW'(1);
            running_sum_in = sum_next;
         end
      end
   end

   // The series result names the source to switch to next.
   always_comb begin
      new_rsp.conversions = sample_total_in;
      if (is_sample) begin
         new_rsp.result_kind = reading_button_ff ? adcs_pkg::KIND_BUTTON : adcs_pkg::KIND_USER;
         new_rsp.average_sum = sum_next;
         new_rsp.next_mux = reading_button_ff ? chan.mux : button_mux_ff;
         new_rsp.user_channel = chan.channel;
      end else begin
         new_rsp.result_kind = adcs_pkg::KIND_CHANNEL;
         new_rsp.average_sum = '0;
         new_rsp.next_mux = chan.mux_next;
         new_rsp.user_channel = chan.channel_next;
      end
      new_valid = series_done || step.step_up || step.step_down;
   end

   // Output register with one skid entry behind it; items leave in arrival order.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in = skid_ff;
      if (out_valid_ff && !pop) begin
         if (new_valid) begin
            skid_valid_in = 1'b1;
            skid_in = new_rsp;
         end
      end else if (skid_valid_ff) begin
         out_valid_in = 1'b1;
         out_in = skid_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = new_valid;
         out_in = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_mux_ff <= '0;
         reading_button_ff <= 1'b1;
         samples_left_ff <= CntLoad;
         running_sum_ff <= '0;
         sample_total_ff <= '0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) begin
            button_mux_ff <= csr.button_mux_code;
         end
         reading_button_ff <= reading_button_in;
         samples_left_ff <= samples_left_in;
         running_sum_ff <= running_sum_in;
         sample_total_ff <= sample_total_in;
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   // The skid entry is only ever filled behind a waiting output.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while the output register is empty");

   // After a channel step the output register always holds a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (step.step_up || step.step_down) |=> out_valid_ff)
      else $error("channel step produced no result");

   assert property (@(posedge clock) disable iff (reset)
      samples_left_ff != '0 && samples_left_ff <= CntLoad)
      else $error("series counter left its range");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.user_channel <= adcs_pkg::BAND_GAP_CHANNEL)
      else $error("user channel beyond the band gap channel");

endmodule
